/* design/windowed_rms_envelope_top_defines.svh */
// Assertion macros shared by the windowed RMS envelope RTL.
// Included by the modules that check their own control logic.
`ifndef WINDOWED_RMS_ENVELOPE_TOP_DEFINES_SVH
`define WINDOWED_RMS_ENVELOPE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* design/wre_pkg.sv */
// Package for the windowed RMS envelope: widths, register indexes and state type.
// No dependencies.
package wre_pkg;
    localparam int MAX_WINDOW  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int WLEN_BITS   = 11;
    localparam int HOP_BITS    = 16;
    localparam int SUM_BITS    = 41;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS   = 16;
    localparam int FRAME_BITS  = 32;
    localparam int CFG_BITS    = 16;
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [0:0] REG_HOP_LEN    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_OLD,
        ST_SQ_NEW,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } wre_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } wre_ctrl_t;
endpackage

/* design/wre_divsqrt.sv */
// Bit-serial unit: floor(sum / window) by restoring division, then integer
// square root one result bit per cycle. Depends on wre_pkg.
`include "windowed_rms_envelope_top_defines.svh"
module wre_divsqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wre_pkg::wre_ctrl_t              ctrl,
    input  logic [wre_pkg::SUM_BITS-1:0]    sum,
    input  logic [wre_pkg::WLEN_BITS-1:0]   divisor,
    output logic                            done,
    output logic [wre_pkg::ROOT_BITS-1:0]   root
);
    import wre_pkg::*;

    localparam int QCNT_BITS = $clog2(SUM_BITS + 1);
    localparam int RROOT     = (SUM_BITS + 1) / 2;

    logic                  phase_reg, phase_next;
    logic                  run_reg, run_next;
    logic [QCNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]   q_reg, q_next;
    logic [WLEN_BITS:0]    rem_reg, rem_next;
    logic [RROOT+1:0]      srem_reg, srem_next;
    logic [RROOT-1:0]      root_reg, root_next;
    logic                  done_reg, done_next;
    logic [WLEN_BITS+1:0]  dtrial;
    logic [RROOT+1:0]      strial;
    logic [RROOT+1:0]      sshift;

    always_comb
    begin
        phase_next = phase_reg;
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        dtrial     = '0;
        strial     = '0;
        sshift     = '0;
        if (ctrl.start)
        begin
            run_next   = 1'b1;
            phase_next = 1'b0;
            cnt_next   = QCNT_BITS'(SUM_BITS);
            q_next     = sum;
            rem_next   = '0;
        end
        else if (run_reg && !phase_reg)
        begin
            // Restoring division: shift the dividend in MSB first.
            dtrial = {rem_reg, q_reg[SUM_BITS-1]} - {2'b00, divisor};
            if (!dtrial[WLEN_BITS+1])
            begin
                rem_next = dtrial[WLEN_BITS:0];
                q_next   = {q_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WLEN_BITS-1:0], q_reg[SUM_BITS-1]};
                q_next   = {q_reg[SUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_BITS'(1))
            begin
                phase_next = 1'b1;
                cnt_next   = QCNT_BITS'(RROOT);
                srem_next  = '0;
                root_next  = '0;
            end
        end
        else if (run_reg)
        begin
            // Square root two quotient bits per step; an odd-width quotient takes
            // a leading zero in its first pair.
            if ((SUM_BITS % 2 == 1) && (cnt_reg == QCNT_BITS'(RROOT)))
            begin
                sshift = {srem_reg[RROOT-1:0], 1'b0, q_reg[SUM_BITS-1]};
                q_next = {q_reg[SUM_BITS-2:0], 1'b0};
            end
            else
            begin
                sshift = {srem_reg[RROOT-1:0], q_reg[SUM_BITS-1:SUM_BITS-2]};
                q_next = {q_reg[SUM_BITS-3:0], 2'b00};
            end
            strial = sshift - {root_reg, 2'b01};
            if (!strial[RROOT+1])
            begin
                srem_next = strial;
                root_next = {root_reg[RROOT-2:0], 1'b1};
            end
            else
            begin
                srem_next = sshift;
                root_next = {root_reg[RROOT-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_BITS-1:0];

    `ASSERT_NEXT(a_done_ends_run, clk, rst_n, done_reg, !run_reg || ctrl.start)
    `ASSERT_IMPLY(a_start_when_idle, clk, rst_n, ctrl.start, !run_reg)
    `ASSERT_IMPLY(a_busy_covers_run, clk, rst_n, run_reg, ctrl.busy)
endmodule

/* design/windowed_rms_envelope_top.sv */
// Windowed RMS envelope: one sample per transfer, at most one result per sample.
// Bit-serial squaring handles the outgoing and then the new sample; no new sample is taken until then.
// A frame end adds 41 division and 21 root steps before m_tvalid rises; the next sample can be
// taken in the same cycle that m_tvalid rises, and a frame waits for the output.
// Reset (rst_n, asynchronous) clears counters and restores default registers; the delay
// line is not reset, as only entries written since the stream start are ever read.
`include "windowed_rms_envelope_top_defines.svh"
module windowed_rms_envelope_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] rms_value, [47:16] frame_index
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import wre_pkg::*;

    wre_state_t                  state_reg, state_next;
    logic [WLEN_BITS-1:0]        wlen_reg;
    logic [HOP_BITS-1:0]         hop_reg;
    logic [SUM_BITS-1:0]         sum_reg, sum_next;
    logic [WLEN_BITS-1:0]        seen_reg, seen_next;
    logic [HOP_BITS-1:0]         phase_reg, phase_next;
    logic [FRAME_BITS-1:0]       frame_reg, frame_next;
    logic [SLOT_BITS-1:0]        slot_reg, slot_next;
    logic [SAMPLE_BITS-1:0]      hist_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]      old_reg, new_reg;
    logic                        full_reg, full_next;
    logic                        emit_reg, emit_next;
    logic [4:0]                  bcnt_reg, bcnt_next;
    logic [SAMPLE_BITS-1:0]      mag_reg, mag_next;
    logic [SQ_BITS-1:0]          sq_reg, sq_next;
    logic                        out_valid_reg;
    logic [ROOT_BITS-1:0]        out_rms_reg;
    logic [FRAME_BITS-1:0]       out_frame_reg;
    logic [WLEN_BITS-1:0]        weff;
    logic [HOP_BITS-1:0]         heff;
    logic [SLOT_BITS-1:0]        old_slot;
    logic                        accept;
    logic                        restart;
    logic                        out_load;
    logic                        dsq_done;
    logic [ROOT_BITS-1:0]        dsq_root;
    wre_ctrl_t                   dsq_ctrl;
    logic [SAMPLE_BITS-1:0]      s_abs;
    logic [SAMPLE_BITS-1:0]      in_sample;
    logic                        in_first;

    assign in_sample = s_tdata;
    assign in_first  = s_tuser;
    assign weff = (wlen_reg == '0) ? WLEN_BITS'(1)
                : (wlen_reg > WLEN_BITS'(MAX_WINDOW)) ? WLEN_BITS'(MAX_WINDOW) : wlen_reg;
    assign heff = (hop_reg == '0) ? HOP_BITS'(1) : hop_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign restart  = accept && in_first;
    assign old_slot = slot_reg - weff[SLOT_BITS-1:0];
    // A finished frame moves to the output register once it is empty or being emptied.
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_BITS'(330);
            hop_reg  <= HOP_BITS'(15);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LEN: wlen_reg <= cfg_data[WLEN_BITS-1:0];
                REG_HOP_LEN:    hop_reg  <= cfg_data[HOP_BITS-1:0];
                default:        wlen_reg <= wlen_reg;
            endcase
        end
    end

    // Delay line: written and read in the same clocked block.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[slot_reg] <= in_sample;
            old_reg            <= hist_mem[old_slot];
            new_reg            <= in_sample;
        end
    end

    assign s_abs = mag_reg;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        phase_next = phase_reg;
        frame_next = frame_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        emit_next  = emit_reg;
        bcnt_next  = bcnt_reg;
        mag_next   = mag_reg;
        sq_next    = sq_reg;
        dsq_ctrl.start = 1'b0;
        dsq_ctrl.busy  = (state_reg == ST_DIV) || (state_reg == ST_SQRT);
        if (cfg_we)
        begin
            sum_next   = '0;
            seen_next  = '0;
            phase_next = '0;
            frame_next = '0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        sum_next   = '0;
                        seen_next  = '0;
                        phase_next = '0;
                        frame_next = '0;
                        full_next  = 1'b0;
                    end
                    else
                        full_next = (seen_reg >= weff);
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Old sample magnitude; zero while the window is still filling.
                mag_next = full_reg
                         ? (old_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-old_reg) : old_reg)
                         : '0;
                sq_next    = '0;
                bcnt_next  = '0;
                state_next = ST_SQ_OLD;
            end
            ST_SQ_OLD:
            begin
                // Shift-and-add square, one multiplier bit per cycle.
                sq_next = {sq_reg[SQ_BITS-2:0], 1'b0}
                        + (s_abs[SAMPLE_BITS-1] ? SQ_BITS'(old_reg[SAMPLE_BITS-1]
                            ? SAMPLE_BITS'(-old_reg) : old_reg) : '0);
                if (!full_reg)
                    sq_next = '0;
                mag_next  = {mag_reg[SAMPLE_BITS-2:0], 1'b0};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == 5'(SAMPLE_BITS - 1))
                begin
                    sum_next   = sum_reg - SUM_BITS'(sq_next);
                    mag_next   = new_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-new_reg) : new_reg;
                    sq_next    = '0;
                    bcnt_next  = '0;
                    state_next = ST_SQ_NEW;
                end
            end
            ST_SQ_NEW:
            begin
                sq_next = {sq_reg[SQ_BITS-2:0], 1'b0}
                        + (s_abs[SAMPLE_BITS-1] ? SQ_BITS'(new_reg[SAMPLE_BITS-1]
                            ? SAMPLE_BITS'(-new_reg) : new_reg) : '0);
                mag_next  = {mag_reg[SAMPLE_BITS-2:0], 1'b0};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == 5'(SAMPLE_BITS - 1))
                begin
                    sum_next  = sum_reg + SUM_BITS'(sq_next);
                    emit_next = 1'b0;
                    if (!full_reg)
                    begin
                        seen_next = seen_reg + 1'b1;
                        if (seen_reg + 1'b1 >= weff)
                        begin
                            emit_next  = 1'b1;
                            phase_next = '0;
                        end
                    end
                    else if (phase_reg + 1'b1 >= heff)
                    begin
                        emit_next  = 1'b1;
                        phase_next = '0;
                    end
                    else
                        phase_next = phase_reg + 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (emit_reg)
                begin
                    dsq_ctrl.start = 1'b1;
                    state_next     = ST_SQRT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_SQRT:
            begin
                if (dsq_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    frame_next = frame_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            seen_reg  <= '0;
            phase_reg <= '0;
            frame_reg <= '0;
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            emit_reg  <= 1'b0;
            bcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            slot_reg  <= slot_next;
            full_reg  <= full_next;
            emit_reg  <= emit_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        sq_reg  <= sq_next;
    end

    wre_divsqrt u_divsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dsq_ctrl),
        .sum     (sum_reg),
        .divisor (weff),
        .done    (dsq_done),
        .root    (dsq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // The root stays stable in the serial unit until its next start.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rms_reg   <= dsq_root;
            out_frame_reg <= frame_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_frame_reg, out_rms_reg};

    `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_tready)
    `ASSERT_NEXT(a_out_sets_valid, clk, rst_n, state_reg == ST_OUT, m_tvalid)
    `ASSERT_IMPLY(a_seen_bounded, clk, rst_n, 1'b1, seen_reg <= weff || cfg_we || $past(cfg_we))
endmodule
